// ----- hdl/tac_pkg.sv -----
// Shared widths, constants and tables of the track acceptance check.
`default_nettype none
package tac_pkg;

  localparam int MOM_WIDTH    = 20;
  localparam int CORDIC_STEPS = 18;
  localparam int GUARD        = 8;

  // cordic datapath
  localparam int CW    = MOM_WIDTH + 1;
  localparam int XW    = CW + GUARD + 2;
  localparam int MAG_W = XW - 1;
  localparam int ZW    = 34;
  localparam int L_C   = CORDIC_STEPS + 1;

  // transverse momentum
  localparam int GAIN_W = 20;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int PT_W   = MOM_WIDTH;
  localparam int CFG_PT_W  = 19;
  localparam int CFG_VTX_W = 15;
  localparam int CFG_W     = 19;
  localparam int PTC_W  = (PT_W > CFG_PT_W) ? PT_W : CFG_PT_W;
  localparam logic [GAIN_W-1:0] GAIN_Q20 = 20'd636751;

  // curvature divider
  localparam int NW  = ((PT_W - 1 > 27) ? PT_W - 1 : 27) + 1;
  localparam int L_D = NW + 1;
  localparam int SAT_W = 19;
  localparam int OFF_W = SAT_W + 1;
  localparam logic [NW-1:0] CURV1 = NW'(64'd63082332);
  localparam logic [NW-1:0] CURV2 = NW'(64'd41607496);
  localparam logic [SAT_W-1:0] CURV_SAT = 19'd262144;

  // angles, Q16
  localparam int ANG_W = ZW - 14;
  localparam int SUM_W = ANG_W + 2;
  localparam int PAD   = L_D - L_C - 1;

  // vertex term
  localparam int VZ_W  = 16;
  localparam int VP_W  = 35;
  localparam int VT_W  = VP_W - 16;
  localparam logic signed [VP_W-1:0] SLOPE_Z = 35'sd255013;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 34'sd6746518852;

  localparam logic signed [SUM_W-1:0] WEST_LO  = -22'sd38601;
  localparam logic signed [SUM_W-1:0] WEST_HI  = 22'sd64356;
  localparam logic signed [SUM_W-1:0] EAST_LO  = 22'sd141558;
  localparam logic signed [SUM_W-1:0] EAST_HI  = 22'sd244515;
  localparam logic signed [SUM_W-1:0] THETA_LO = 22'sd79954;
  localparam logic signed [SUM_W-1:0] THETA_HI = 22'sd125829;

  // configuration register indexes
  localparam logic REG_MIN_PT  = 1'b0;
  localparam logic REG_MAX_VTX = 1'b1;
  localparam logic [CFG_PT_W-1:0]  MIN_PT_RESET  = 19'd819;
  localparam logic [CFG_VTX_W-1:0] MAX_VTX_RESET = 15'd1920;

  // stream widths
  localparam int IN_W   = 3 * MOM_WIDTH + VZ_W + 2;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TW = 8;

  localparam logic [31:0] ATAN_Q30 [24] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage
`default_nettype wire

// ----- hdl/tac_cordic.sv -----
// Pipelined vectoring CORDIC: one rotation per stage, angle in Q30.
`default_nettype none
module tac_cordic (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          ce_i,
  input  wire logic                          valid_i,
  input  wire logic signed [tac_pkg::CW-1:0] x_i,
  input  wire logic signed [tac_pkg::CW-1:0] y_i,
  output logic                               valid_o,
  output logic [tac_pkg::MAG_W-1:0]          mag_o,
  output logic signed [tac_pkg::ZW-1:0]      ang_o
);
  import tac_pkg::*;

  logic                 v_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];

  logic signed [XW-1:0] x_ext, y_ext, x0_d, y0_d;
  logic signed [ZW-1:0] z0_d;

  // fold the left half plane over
  always_comb begin
    x_ext = {{(XW-CW){x_i[CW-1]}}, x_i} <<< GUARD;
    y_ext = {{(XW-CW){y_i[CW-1]}}, y_i} <<< GUARD;
    if (x_i[CW-1]) begin
      x0_d = -x_ext;
      y0_d = -y_ext;
      z0_d = y_i[CW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x0_d = x_ext;
      y0_d = y_ext;
      z0_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= CORDIC_STEPS; k++) v_q[k] <= 1'b0;
    end else if (ce_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= CORDIC_STEPS; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] da;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign da = $signed({{(ZW-32){1'b0}}, ATAN_Q30[i]});
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + da;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - da;
        end
      end
    end
  end

  assign valid_o = v_q[CORDIC_STEPS];
  assign mag_o   = (x_q[CORDIC_STEPS] > 0) ? x_q[CORDIC_STEPS][MAG_W-1:0] : '0;
  assign ang_o   = z_q[CORDIC_STEPS];

endmodule
`default_nettype wire

// ----- hdl/tac_div.sv -----
// Pipelined restoring dividers for the two curvature offsets.
`default_nettype none
module tac_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            ce_i,
  input  wire logic                            valid_i,
  input  wire logic [tac_pkg::PT_W-1:0]        pt_i,
  input  wire logic signed [1:0]               charge_i,
  output logic                                 valid_o,
  output logic signed [tac_pkg::OFF_W-1:0]     off1_o,
  output logic signed [tac_pkg::OFF_W-1:0]     off2_o
);
  import tac_pkg::*;

  logic              v_q   [NW+1];
  logic [NW-1:0]     n1_q  [NW+1];
  logic [NW-1:0]     n2_q  [NW+1];
  logic [PT_W:0]     r1_q  [NW+1];
  logic [PT_W:0]     r2_q  [NW+1];
  logic [PT_W-1:0]   d_q   [NW+1];
  logic              neg_q [NW+1];

  logic [NW-1:0] k1, k2, half;
  logic [SAT_W-1:0] s1, s2;

  // |q| times the constant, plus half the divisor for rounding
  always_comb begin
    half = NW'(pt_i >> 1);
    case (charge_i)
      2'sb01, 2'sb11: begin
        k1 = CURV1;
        k2 = CURV2;
      end
      2'sb10: begin
        k1 = CURV1 << 1;
        k2 = CURV2 << 1;
      end
      default: begin
        k1 = '0;
        k2 = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NW; k++) v_q[k] <= 1'b0;
    end else if (ce_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k <= NW; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      n1_q[0]  <= k1 + half;
      n2_q[0]  <= k2 + half;
      r1_q[0]  <= '0;
      r2_q[0]  <= '0;
      d_q[0]   <= pt_i;
      neg_q[0] <= charge_i[1];
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_bit
    logic [PT_W:0] t1, t2, dd;
    logic          b1, b2;
    assign dd = {1'b0, d_q[i]};
    assign t1 = {r1_q[i][PT_W-1:0], n1_q[i][NW-1]};
    assign t2 = {r2_q[i][PT_W-1:0], n2_q[i][NW-1]};
    assign b1 = (t1 >= dd);
    assign b2 = (t2 >= dd);
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        r1_q[i+1]  <= b1 ? t1 - dd : t1;
        r2_q[i+1]  <= b2 ? t2 - dd : t2;
        n1_q[i+1]  <= {n1_q[i][NW-2:0], b1};
        n2_q[i+1]  <= {n2_q[i][NW-2:0], b2};
        d_q[i+1]   <= d_q[i];
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  // saturate and apply the charge sign
  always_comb begin
    s1 = (n1_q[NW] > NW'(CURV_SAT)) ? CURV_SAT : n1_q[NW][SAT_W-1:0];
    s2 = (n2_q[NW] > NW'(CURV_SAT)) ? CURV_SAT : n2_q[NW][SAT_W-1:0];
    off1_o = neg_q[NW] ? -$signed({1'b0, s1}) : $signed({1'b0, s1});
    off2_o = neg_q[NW] ? -$signed({1'b0, s2}) : $signed({1'b0, s2});
  end

  assign valid_o = v_q[NW];

endmodule
`default_nettype wire

// ----- hdl/track_acceptance_check.sv -----
// Top level of the track acceptance check: stream ports, cuts and arm windows.
// Takes one track per clock while the output does not stall and returns one accepted/arm
// request per track, in order. The azimuth CORDIC (one stage per rotation) is followed by
// the curvature dividers (one stage per quotient bit), with the polar-angle CORDIC running
// beside the dividers.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module track_acceptance_check (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [tac_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // mom_x, mom_y, mom_z, vertex_z, track_charge, zero fill
  input  wire logic [tac_pkg::IN_TW-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // accepted, arm, zero fill
  output logic [tac_pkg::OUT_TW-1:0]           m_axis_tdata
);
  import tac_pkg::*;

  typedef struct packed {
    logic signed [MOM_WIDTH-1:0] pz;
    logic signed [VZ_W-1:0]      vz;
    logic signed [1:0]           q;
  } front_t;

  typedef struct packed {
    logic                    rej;
    logic signed [ANG_W-1:0] phi;
  } back_t;

  logic ce;
  logic [CFG_PT_W-1:0]  min_pt_q;
  logic [CFG_VTX_W-1:0] max_vtx_q;

  logic                        v0_q;
  logic signed [MOM_WIDTH-1:0] px0_q, py0_q;
  front_t                      f0_q;

  logic                 c1_v;
  logic [MAG_W-1:0]     c1_mag;
  logic signed [ZW-1:0] c1_ang;
  front_t               f1_q [L_C];

  logic                    vm_q;
  logic [PROD_W-1:0]       prod_q;
  logic signed [ZW-1:0]    angm_q;
  logic signed [VP_W-1:0]  vprod_q;
  front_t                  fm_q;

  logic                    vp_q;
  logic [PT_W-1:0]         pt_q;
  logic signed [ANG_W-1:0] phi_q;
  logic                    rej_q;
  logic signed [VT_W-1:0]  vterm_q;
  logic signed [MOM_WIDTH-1:0] pzp_q;
  logic signed [1:0]       qp_q;

  logic [PROD_W:0]         pt_sum;
  logic [PT_W-1:0]         pt_d;
  logic signed [ZW-1:0]    ang_adj;
  logic signed [ZW-1:0]    ang_rnd;
  logic [VZ_W:0]           avz;
  logic signed [VP_W-1:0]  vz_ext, vt_sum;
  logic                    rej_d;

  logic                    dv;
  logic signed [OFF_W-1:0] off1, off2;

  logic signed [ZW-1:0]    c2_ang;
  logic signed [ZW-1:0]    th_rnd;
  logic signed [VT_W-1:0]  vt2_q [L_C];
  logic signed [SUM_W-1:0] th_q  [PAD+1];
  back_t                   b_q   [L_D];

  logic signed [SUM_W-1:0] p1, p2, th;
  logic                    west, east, acc;
  logic                    vo_q, acc_q, arm_q;

  assign ce = !vo_q || m_axis_tready;
  assign s_axis_tready = ce;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pt_q  <= MIN_PT_RESET;
      max_vtx_q <= MAX_VTX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN_PT:  min_pt_q  <= cfg_data_i[CFG_PT_W-1:0];
        REG_MAX_VTX: max_vtx_q <= cfg_data_i[CFG_VTX_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vm_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (ce) begin
      v0_q <= s_axis_tvalid;
      vm_q <= c1_v;
      vp_q <= vm_q;
      vo_q <= dv;
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (ce) begin
      px0_q   <= s_axis_tdata[MOM_WIDTH-1:0];
      py0_q   <= s_axis_tdata[2*MOM_WIDTH-1:MOM_WIDTH];
      f0_q.pz <= s_axis_tdata[3*MOM_WIDTH-1:2*MOM_WIDTH];
      f0_q.vz <= s_axis_tdata[3*MOM_WIDTH+VZ_W-1:3*MOM_WIDTH];
      f0_q.q  <= s_axis_tdata[IN_W-1:3*MOM_WIDTH+VZ_W];
    end
  end

  tac_cordic u_cordic_phi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (v0_q),
    .x_i     ({px0_q[MOM_WIDTH-1], px0_q}),
    .y_i     ({py0_q[MOM_WIDTH-1], py0_q}),
    .valid_o (c1_v),
    .mag_o   (c1_mag),
    .ang_o   (c1_ang)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      f1_q[0] <= f0_q;
      for (int k = 1; k < L_C; k++) f1_q[k] <= f1_q[k-1];
    end
  end

  // gain multiply and vertex product
  assign vz_ext = {{(VP_W-VZ_W){f1_q[L_C-1].vz[VZ_W-1]}}, f1_q[L_C-1].vz};

  always_ff @(posedge clk_i) begin
    if (ce) begin
      prod_q  <= PROD_W'(c1_mag) * PROD_W'(GAIN_Q20);
      angm_q  <= c1_ang;
      vprod_q <= vz_ext * SLOPE_Z;
      fm_q    <= f1_q[L_C-1];
    end
  end

  // transverse momentum, azimuth, early cuts
  always_comb begin
    pt_sum  = {1'b0, prod_q} + ((PROD_W+1)'(1) << 27);
    pt_d    = pt_sum[PT_W+27:28];
    ang_adj = (angm_q < -HALF_PI_Q30) ? angm_q + TWO_PI_Q30 : angm_q;
    ang_rnd = ang_adj + ZW'(1 << 13);
    avz     = fm_q.vz[VZ_W-1] ? -{fm_q.vz[VZ_W-1], fm_q.vz} : {1'b0, fm_q.vz};
    vt_sum  = vprod_q + VP_W'(1 << 15);
    rej_d   = (pt_d == '0) || (avz > {2'b00, max_vtx_q})
           || (PTC_W'(pt_d) < PTC_W'(min_pt_q));
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      pt_q    <= pt_d;
      phi_q   <= ang_rnd[ZW-1:14];
      rej_q   <= rej_d;
      vterm_q <= vt_sum[VP_W-1:16];
      pzp_q   <= fm_q.pz;
      qp_q    <= fm_q.q;
    end
  end

  tac_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ce_i     (ce),
    .valid_i  (vp_q),
    .pt_i     (pt_q),
    .charge_i (qp_q),
    .valid_o  (dv),
    .off1_o   (off1),
    .off2_o   (off2)
  );

  tac_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (vp_q),
    .x_i     ({pzp_q[MOM_WIDTH-1], pzp_q}),
    .y_i     ({1'b0, pt_q}),
    .valid_o (),
    .mag_o   (),
    .ang_o   (c2_ang)
  );

  assign th_rnd = c2_ang + ZW'(1 << 13);

  // align the polar angle and azimuth with the divider output
  always_ff @(posedge clk_i) begin
    if (ce) begin
      vt2_q[0] <= vterm_q;
      for (int k = 1; k < L_C; k++) vt2_q[k] <= vt2_q[k-1];
      th_q[0] <= SUM_W'(th_rnd[ZW-1:14]) - SUM_W'(vt2_q[L_C-1]);
      for (int k = 1; k <= PAD; k++) th_q[k] <= th_q[k-1];
      b_q[0] <= '{rej: rej_q, phi: phi_q};
      for (int k = 1; k < L_D; k++) b_q[k] <= b_q[k-1];
    end
  end

  // arm windows and polar cut
  always_comb begin
    p1   = SUM_W'(b_q[L_D-1].phi) + SUM_W'(off1);
    p2   = SUM_W'(b_q[L_D-1].phi) + SUM_W'(off2);
    th   = th_q[PAD];
    west = (p1 > WEST_LO) && (p1 < WEST_HI) && (p2 > WEST_LO) && (p2 < WEST_HI);
    east = (p1 > EAST_LO) && (p1 < EAST_HI) && (p2 > EAST_LO) && (p2 < EAST_HI);
    acc  = !b_q[L_D-1].rej && (west || east) && (th >= THETA_LO) && (th <= THETA_HI);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      acc_q <= acc;
      arm_q <= acc && west;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {{(OUT_TW-2){1'b0}}, arm_q, acc_q};

endmodule
`default_nettype wire

// ----- tb/track_acceptance_check_test.sv -----
// Self-checking stream testbench of the track acceptance check, with a predictor of the cuts.
`timescale 1ns / 100ps
`default_nettype none
module track_acceptance_check_test;
  import tac_pkg::*;

  typedef struct packed {
    logic signed [1:0]  charge;
    logic signed [15:0] vtx;
    logic signed [19:0] pz;
    logic signed [19:0] py;
    logic signed [19:0] px;
  } track_t;

  typedef struct packed {
    logic arm;
    logic accepted;
  } verdict_t;

  localparam longint PI_Q30_L    = 64'sd3373259426;
  localparam longint HALF_PI_L   = 64'sd1686629713;
  localparam longint TWO_PI_L    = 64'sd6746518852;
  localparam int     WATCH_LIMIT = 5000;
  localparam int     DRAIN_WAIT  = 80;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_idx_i;
  logic [CFG_W-1:0]    cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // mom_x, mom_y, mom_z, vertex_z, track_charge, zero fill
  logic [IN_TW-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // accepted, arm, zero fill
  logic [OUT_TW-1:0]   m_axis_tdata;

  track_t   pending_tracks[$];
  verdict_t expected_verdicts[$];
  longint   low_pt_limit;
  longint   max_vtx_cut;
  int       fail_count = 0;
  int       send_gap;
  int       recv_gap;
  bit       quiet;
  int       idle_cycles = 0;

  track_acceptance_check DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint cordic_vector(input longint x_in, input longint y_in,
                                           output longint mag);
    longint x, y, z, dx, dy;
    x = x_in * 256;
    y = y_in * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30_L : -PI_Q30_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_Q30[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_Q30[i]);
      end
    end
    mag = (x > 0) ? x : 0;
    return z;
  endfunction

  function automatic longint bend_offset(input longint q, input longint pt, input longint k);
    longint v;
    v = ((q < 0 ? -q : q) * k + pt / 2) / pt;
    if (v > 262144) v = 262144;
    return (q < 0) ? -v : v;
  endfunction

  function automatic verdict_t judge_track(input track_t t);
    verdict_t r;
    longint mag, pt, phi, theta, p1, p2, th, vz, q;
    int side;
    r = '0;
    side = -1;
    vz = t.vtx;
    q = t.charge;
    phi = cordic_vector(t.px, t.py, mag);
    pt = (mag * 636751 + (64'sd1 <<< 27)) >>> 28;
    if (pt == 0) return r;
    if ((vz < 0 ? -vz : vz) > max_vtx_cut) return r;
    if (pt < low_pt_limit) return r;
    if (phi < -HALF_PI_L) phi = phi + TWO_PI_L;
    phi = (phi + 8192) >>> 14;
    p1 = phi + bend_offset(q, pt, 63082332);
    p2 = phi + bend_offset(q, pt, 41607496);
    if (p1 > -38601 && p1 < 64356 && p2 > -38601 && p2 < 64356) side = 1;
    if (p1 > 141558 && p1 < 244515 && p2 > 141558 && p2 < 244515) side = 0;
    if (side < 0) return r;
    theta = cordic_vector(t.pz, pt, mag);
    theta = (theta + 8192) >>> 14;
    th = theta - ((vz * 255013 + 32768) >>> 16);
    if (th > 125829 || th < 79954) return r;
    r.accepted = 1'b1;
    r.arm = side[0];
    return r;
  endfunction

  // driver: hold the request until taken, predict it on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_verdicts.push_back(judge_track(track_t'(s_axis_tdata[77:0])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_tracks.size() > 0) begin
          s_axis_tdata  <= {2'b00, pending_tracks.pop_front()};
          s_axis_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, compare each verdict with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    int       errs;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        errs = 0;
        if (expected_verdicts.size() == 0) begin
          $error("unexpected verdict %h", m_axis_tdata);
          errs = 1;
        end else begin
          want = expected_verdicts.pop_front();
          if (m_axis_tdata[0] !== want.accepted) begin
            $error("accepted: expected %b actual %b", want.accepted, m_axis_tdata[0]);
            errs = errs + 1;
          end
          if (m_axis_tdata[1] !== want.arm) begin
            $error("arm: expected %b actual %b", want.arm, m_axis_tdata[1]);
            errs = errs + 1;
          end
        end
        if (errs > 0) fail_count <= fail_count + errs;
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap      <= $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles without progress while work is outstanding
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_tracks.size() == 0 && expected_verdicts.size() == 0 && !s_axis_tvalid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("track_acceptance_check regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input longint value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MIN_PT) low_pt_limit = value & 19'h7FFFF;
    else max_vtx_cut = value & 15'h7FFF;
  endtask

  task automatic drain();
    while (pending_tracks.size() > 0 || s_axis_tvalid || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic track_t noise_track();
    track_t t;
    t = track_t'(78'({$urandom(), $urandom(), $urandom()}));
    return t;
  endfunction

  // plausible track aimed at one arm, with polar angle near the window
  function automatic track_t aimed_track();
    track_t t;
    real r, a, th;
    r = $urandom_range(600, 60000);
    if ($urandom_range(0, 1)) a = -0.75 + 1.9 * $urandom_range(0, 10000) / 10000.0;
    else a = 2.0 + 1.9 * $urandom_range(0, 10000) / 10000.0;
    th = 1.1 + 0.95 * $urandom_range(0, 10000) / 10000.0;
    t.px = 20'($rtoi(r * $cos(a)));
    t.py = 20'($rtoi(r * $sin(a)));
    t.pz = 20'($rtoi(r * $cos(th) / $sin(th)));
    t.vtx = $signed(16'($urandom_range(0, 4400))) - 16'sd2200;
    t.charge = 2'($urandom_range(0, 3));
    return t;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      pending_tracks.push_back(($urandom_range(0, 4) == 0) ? noise_track() : aimed_track());
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    low_pt_limit  = 819;
    max_vtx_cut   = 1920;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero pt, track along -y, both arms, charge -2
    pending_tracks.push_back('{charge: 2'sd1, vtx: 16'sd0, pz: 20'sd0, py: 20'sd0, px: 20'sd0});
    pending_tracks.push_back('{charge: -2'sd1, vtx: 16'sd0, pz: 20'sd0, py: -20'sd8192,
                               px: 20'sd0});
    pending_tracks.push_back('{charge: 2'sd0, vtx: 16'sd0, pz: 20'sd0, py: 20'sd0,
                               px: 20'sd8192});
    pending_tracks.push_back('{charge: 2'sd0, vtx: 16'sd0, pz: 20'sd0, py: 20'sd0,
                               px: -20'sd8192});
    pending_tracks.push_back('{charge: -2'sd2, vtx: 16'sd100, pz: 20'sd500, py: 20'sd1000,
                               px: 20'sd8000});
    pending_tracks.push_back('{charge: -2'sd2, vtx: 16'sd0, pz: 20'sd0, py: 20'sd0,
                               px: 20'sd819});
    pending_tracks.push_back('{charge: 2'sd1, vtx: 16'sd1920, pz: 20'sd0, py: 20'sd0,
                               px: 20'sd20000});
    pending_tracks.push_back('{charge: 2'sd1, vtx: -16'sd1921, pz: 20'sd0, py: 20'sd0,
                               px: 20'sd20000});
    pending_tracks.push_back('{charge: -2'sd1, vtx: 16'sd32767, pz: 20'sd524287,
                               py: 20'sd524287, px: 20'sd524287});
    pending_tracks.push_back('{charge: -2'sd2, vtx: -16'sd32768, pz: -20'sd524288,
                               py: -20'sd524288, px: -20'sd524288});
    pending_tracks.push_back('{charge: 2'sd1, vtx: 16'sd0, pz: 20'sd0, py: 20'sd1,
                               px: 20'sd0});
    repeat (8) pending_tracks.push_back(aimed_track());
    drain();

    write_reg(REG_MIN_PT, 0);
    write_reg(REG_MAX_VTX, 32767);
    pending_tracks.push_back('{charge: -2'sd2, vtx: 16'sd0, pz: 20'sd0, py: 20'sd0,
                               px: 20'sd3});
    pending_tracks.push_back('{charge: 2'sd1, vtx: -16'sd32768, pz: 20'sd0, py: 20'sd0,
                               px: 20'sd20000});
    queue_random(150);
    drain();

    write_reg(REG_MIN_PT, 524287);
    write_reg(REG_MAX_VTX, 0);
    queue_random(100);
    drain();

    write_reg(REG_MIN_PT, $urandom_range(0, 4000));
    write_reg(REG_MAX_VTX, $urandom_range(0, 4000));
    queue_random(200);
    drain();

    write_reg(REG_MIN_PT, 819);
    write_reg(REG_MAX_VTX, 1920);
    queue_random(229);
    while (pending_tracks.size() > 60) @(posedge clk_i);
    quiet = 1'b1;
    drain();

    if (fail_count == 0) begin
      $display("track_acceptance_check regression: pass");
    end else begin
      $display("track_acceptance_check regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
